// File: hw/rtl/vlpd_pkg.sv
// shared types and constants for the varint length-prefix deframer
`timescale 1ns / 1ps

package vlpd_pkg;

  localparam int MAX_PREFIX_BYTES = 5;
  localparam int LEN_W = 21;
  localparam int BYTE_W = 8;
  localparam int DIGIT_W = 7;
  localparam int ACC_RAW_W = DIGIT_W * MAX_PREFIX_BYTES;
  localparam int ACC_W = (ACC_RAW_W > LEN_W) ? ACC_RAW_W : LEN_W + 1;
  localparam int CNT_W = $clog2(MAX_PREFIX_BYTES + 1);
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_VARINT    = 2'd1,
    ERR_TOO_LARGE = 2'd2
  } err_t;

  typedef enum logic {
    REG_MAX_FRAME_LENGTH = 1'b0
  } reg_idx_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] payload_byte;
    logic              first;
    logic              last;
    logic [LEN_W-1:0]  frame_length;
    err_t              error_code;
  } result_t;

endpackage

// File: hw/rtl/vlpd_apb_regs.sv
// apb configuration register holding the maximum frame length
`timescale 1ns / 1ps

module vlpd_apb_regs import vlpd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [LEN_W-1:0]  max_frame_length
);

  reg_idx_t reg_idx;
  logic     addr_hit;
  logic     wr_en;

  assign reg_idx  = reg_idx_t'(paddr[ADDR_W-1]);
  assign addr_hit = (paddr[ADDR_W-2:0] == '0) && (reg_idx == REG_MAX_FRAME_LENGTH);
  assign wr_en    = psel && penable && pwrite && addr_hit;
  assign pready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_length <= LEN_MAX;
    end else if (wr_en) begin
      max_frame_length <= pwdata[LEN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (addr_hit) begin
      prdata = DATA_W'(max_frame_length);
    end
  end

endmodule

// File: hw/rtl/vlpd_parser.sv
// length prefix decode and payload tracking, one byte per step
`timescale 1ns / 1ps

module vlpd_parser import vlpd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [BYTE_W-1:0] stream_byte,
  input  logic [LEN_W-1:0]  max_frame_length,
  output logic              res_valid,
  output result_t           res
);

  logic             in_payload, in_payload_next;
  logic [CNT_W-1:0] prefix_byte_count, prefix_byte_count_next;
  logic [ACC_W-1:0] length_accumulator, length_accumulator_next;
  logic [LEN_W-1:0] bytes_remaining, bytes_remaining_next;

  logic [ACC_W-1:0] acc_base;
  logic [ACC_W-1:0] acc_digit;
  logic [ACC_W-1:0] acc_new;
  logic [LEN_W-1:0] acc_sat;
  logic [LEN_W-1:0] rem_dec;

  always_comb begin
    acc_digit = '0;
    for (int i = 0; i < MAX_PREFIX_BYTES; i++) begin
      if (prefix_byte_count == CNT_W'(i)) begin
        acc_digit = ACC_W'(stream_byte[DIGIT_W-1:0]) << (DIGIT_W * i);
      end
    end
  end

  assign acc_base = (prefix_byte_count == '0) ? '0 : length_accumulator;
  assign acc_new  = acc_base | acc_digit;
  assign acc_sat  = (|acc_new[ACC_W-1:LEN_W]) ? LEN_MAX : acc_new[LEN_W-1:0];
  assign rem_dec  = bytes_remaining - LEN_W'(1);

  always_comb begin
    in_payload_next         = in_payload;
    prefix_byte_count_next  = prefix_byte_count;
    length_accumulator_next = length_accumulator;
    bytes_remaining_next    = bytes_remaining;
    res_valid               = 1'b0;
    res                     = '{kind: KIND_PAYLOAD, payload_byte: '0, first: 1'b0,
                                last: 1'b0, frame_length: '0, error_code: ERR_NONE};

    if (in_payload && (bytes_remaining != '0)) begin
      // payload byte
      res_valid          = 1'b1;
      res.payload_byte   = stream_byte;
      res.first          = (bytes_remaining == length_accumulator[LEN_W-1:0]);
      res.last           = (rem_dec == '0);
      res.frame_length   = length_accumulator[LEN_W-1:0];
      bytes_remaining_next = rem_dec;
      if (rem_dec == '0) begin
        in_payload_next         = 1'b0;
        prefix_byte_count_next  = '0;
        length_accumulator_next = '0;
      end
    end else if (prefix_byte_count >= CNT_W'(MAX_PREFIX_BYTES)) begin
      // prefix too long
      res_valid               = 1'b1;
      res.kind                = KIND_ERROR;
      res.error_code          = ERR_VARINT;
      in_payload_next         = 1'b0;
      prefix_byte_count_next  = '0;
      length_accumulator_next = '0;
      bytes_remaining_next    = '0;
    end else if (stream_byte[BYTE_W-1]) begin
      // more length bytes follow
      length_accumulator_next = acc_new;
      prefix_byte_count_next  = prefix_byte_count + CNT_W'(1);
    end else if (acc_new > ACC_W'(max_frame_length)) begin
      res_valid               = 1'b1;
      res.kind                = KIND_ERROR;
      res.error_code          = ERR_TOO_LARGE;
      res.frame_length        = acc_sat;
      in_payload_next         = 1'b0;
      prefix_byte_count_next  = '0;
      length_accumulator_next = '0;
      bytes_remaining_next    = '0;
    end else if (acc_new == '0) begin
      res_valid               = 1'b1;
      res.kind                = KIND_EMPTY;
      in_payload_next         = 1'b0;
      prefix_byte_count_next  = '0;
      length_accumulator_next = '0;
      bytes_remaining_next    = '0;
    end else begin
      in_payload_next         = 1'b1;
      prefix_byte_count_next  = '0;
      length_accumulator_next = acc_new;
      bytes_remaining_next    = acc_new[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload         <= 1'b0;
      prefix_byte_count  <= '0;
      length_accumulator <= '0;
      bytes_remaining    <= '0;
    end else if (step) begin
      in_payload         <= in_payload_next;
      prefix_byte_count  <= prefix_byte_count_next;
      length_accumulator <= length_accumulator_next;
      bytes_remaining    <= bytes_remaining_next;
    end
  end

  a_payload_no_prefix: assert property (@(posedge clk) disable iff (rst)
    in_payload |-> (prefix_byte_count == '0) && (bytes_remaining != '0))
    else $error("payload state with prefix count or nothing remaining");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    prefix_byte_count <= CNT_W'(MAX_PREFIX_BYTES))
    else $error("prefix byte count out of range");

  a_remaining_within_length: assert property (@(posedge clk) disable iff (rst)
    in_payload |-> (ACC_W'(bytes_remaining) <= length_accumulator))
    else $error("remaining count above frame length");

  a_hold_without_step: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(bytes_remaining) && $stable(in_payload))
    else $error("parser state moved without a step");

endmodule

// File: hw/rtl/vlpd_out_stage.sv
// result register between the parser and the output channel
`timescale 1ns / 1ps

module vlpd_out_stage import vlpd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  output logic    can_take,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  assign can_take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> can_take)
    else $error("result loaded over a pending request");

  a_error_has_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_res.kind == KIND_ERROR) |-> (out_res.error_code != ERR_NONE))
    else $error("error result without a code");

  a_marks_only_on_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_res.kind != KIND_PAYLOAD) |->
      !out_res.first && !out_res.last && (out_res.payload_byte == '0))
    else $error("payload fields set on a non-payload result");

endmodule

// File: hw/rtl/varint_length_prefix_deframer.sv
// top level of the varint length-prefix deframer
//
//   channel   signals                          direction  request moves
//   input     in_valid/in_ready, stream_byte   in         one stream byte
//   output    out_valid/out_ready, result_*    out        one result (or none per byte)
//   config    psel/penable/pwrite/paddr/...    in         max_frame_length write
//
// one byte per cycle sustained unless a held result stalls the input
// input register, combinational decode, result register; length state updates per byte
// synchronous active-high reset clears state and sets max_frame_length to all ones
// a held result stalls only bytes that produce a result; prefix bytes keep flowing
`timescale 1ns / 1ps

module varint_length_prefix_deframer import vlpd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] stream_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        result_kind,
  output logic [BYTE_W-1:0] payload_byte,
  output logic              first_of_frame,
  output logic              last_of_frame,
  output logic [LEN_W-1:0]  frame_length,
  output logic [1:0]        error_code
);

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              step;
  logic              res_valid;
  logic              can_take;
  logic [LEN_W-1:0]  max_frame_length;
  result_t           res;
  result_t           out_res;

  vlpd_apb_regs u_regs (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .max_frame_length (max_frame_length)
  );

  assign step     = s1_valid && (!res_valid || can_take);
  assign in_ready = !s1_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= stream_byte;
    end
  end

  vlpd_parser u_parser (
    .clk              (clk),
    .rst              (rst),
    .step             (step),
    .stream_byte      (s1_byte),
    .max_frame_length (max_frame_length),
    .res_valid        (res_valid),
    .res              (res)
  );

  vlpd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step && res_valid),
    .res       (res),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign result_kind    = out_res.kind;
  assign payload_byte   = out_res.payload_byte;
  assign first_of_frame = out_res.first;
  assign last_of_frame  = out_res.last;
  assign frame_length   = out_res.frame_length;
  assign error_code     = out_res.error_code;

endmodule
